@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when the trigger holds, the result holds in the cycle after
`define ASSERT_NEXT(lbl, trig, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) else $error(msg);

`endif

@@ rtl/psl_pkg.sv @@
// constants and widths of the 3d position step limiter
package psl_pkg;
	localparam int CW = 32;
	localparam int DW = CW + 1;
	localparam int MW = 2 * DW;
	localparam int SW = 31;
	localparam int GW = 17;
	localparam int GAIN_SHIFT = 16;
	localparam logic [GW-1:0] GAIN_ONE = GW'(65536);
	localparam logic [SW-1:0] STEP_LIMIT_RESET = SW'(589824);
	localparam logic REG_STEP_LIMIT = 1'b0;
	localparam logic REG_SMOOTH_GAIN = 1'b1;
endpackage

@@ rtl/psl_mul.sv @@
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
module psl_mul import psl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic          done,
	output logic [MW-1:0] prod
);
	localparam int NW = $clog2(DW);

	logic [MW-1:0] acc_q;
	logic [DW-1:0] a_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   part;

	assign part = {1'b0, acc_q[MW-1:DW]} + (acc_q[0] ? {1'b0, a_q} : (DW+1)'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			acc_q <= {DW'(0), b};
		end else if (busy_q) begin
			acc_q <= {part, acc_q[DW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ rtl/psl_sqrt.sv @@
// restoring integer square root, two radicand bits per cycle
module psl_sqrt import psl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] rad,
	output logic          done,
	output logic [DW-1:0] root
);
	localparam int NW = $clog2(DW);

	logic [MW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] q_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW+2:0] t;
	logic [DW+2:0] trial;

	assign t = {r_q, n_q[MW-1:MW-2]};
	assign trial = {1'b0, q_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= rad;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[MW-3:0], 2'b00};
			if (t >= trial) begin
				r_q <= (DW+1)'(t - trial);
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= t[DW:0];
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = q_q;
endmodule

@@ rtl/psl_div.sv @@
// restoring long division, one quotient bit per cycle
module psl_div import psl_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [DW-1:0] quot
);
	localparam int NW = $clog2(MW);

	logic [MW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] q_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   t;

	assign t = {r_q, n_q[MW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[MW-2:0], 1'b0};
			if (t >= {1'b0, d_q}) begin
				r_q <= DW'(t - {1'b0, d_q});
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= t[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

@@ rtl/position_step_limiter_3d.sv @@
// 3d position step limiter: sequencer around serial multiplier, root and divider
// load beat: accept goes straight to ST_OUT, which registers the result; track
// beat: length set by the bit-serial multiplier (6 products, or 9 when the step
// is clipped), the bit-serial root and three divisions; output stalls add on
// one beat in flight, next accept the cycle after the result is registered
// reset: position zero, step limit 9.0, smooth_gain 1.0, no result pending
module position_step_limiter_3d import psl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic signed [CW-1:0] target_x,
	input  logic signed [CW-1:0] target_y,
	input  logic signed [CW-1:0] target_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [CW-1:0] pos_x,
	output logic signed [CW-1:0] pos_y,
	output logic signed [CW-1:0] pos_z,
	output logic                 clipped
);
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_GAIN, ST_SQR, ST_ROOT, ST_SCALE, ST_DIV, ST_UPD, ST_OUT
	} state_t;

	localparam logic signed [CW+2:0] POS_MAX = (CW+3)'((64'sd1 <<< (CW - 1)) - 1);
	localparam logic signed [CW+2:0] POS_MIN = -POS_MAX - (CW+3)'(1);

	state_t               state_q;
	logic [SW-1:0]        step_limit_q;
	logic [GW-1:0]        smooth_gain_q;
	logic [GW-1:0]        gain_q;
	logic signed [CW-1:0] cur_q [3];
	logic [DW-1:0]        mag_q [3];
	logic [2:0]           neg_q;
	logic [MW-1:0]        sum_q;
	logic [DW-1:0]        len_q;
	logic [1:0]           k_q;
	logic                 clip_q;
	logic                 mul_go_q;
	logic                 sqrt_go_q;
	logic                 div_go_q;
	logic                 out_valid_q;
	logic signed [CW-1:0] pos_q [3];
	logic                 clipped_q;

	logic signed [CW-1:0] tgt [3];
	logic signed [DW-1:0] dif [3];
	logic signed [CW+2:0] nxt [3];
	logic [DW-1:0]        mul_b;
	logic                 mul_done;
	logic [MW-1:0]        mul_prod;
	logic                 sqrt_done;
	logic [DW-1:0]        sqrt_root;
	logic                 div_done;
	logic [DW-1:0]        div_quot;
	logic                 scaling;
	logic                 root_short;

	assign tgt[0] = target_x;
	assign tgt[1] = target_y;
	assign tgt[2] = target_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dif[k] = DW'(tgt[k]) - DW'(cur_q[k]);
			if (neg_q[k])
				nxt[k] = (CW+3)'(cur_q[k]) - $signed({2'b00, mag_q[k]});
			else
				nxt[k] = (CW+3)'(cur_q[k]) + $signed({2'b00, mag_q[k]});
			if (nxt[k] > POS_MAX)
				nxt[k] = POS_MAX;
			else if (nxt[k] < POS_MIN)
				nxt[k] = POS_MIN;
		end
	end

	always_comb begin
		case (state_q)
			ST_GAIN: mul_b = DW'(gain_q);
			ST_SQR:  mul_b = mag_q[k_q];
			default: mul_b = DW'(step_limit_q);
		endcase
	end

	psl_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mag_q[k_q]), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	psl_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_go_q), .rad(sum_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	psl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(mul_prod), .den(len_q),
		.done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_limit_q <= STEP_LIMIT_RESET;
			smooth_gain_q <= GAIN_ONE;
			gain_q <= GAIN_ONE;
			for (int k = 0; k < 3; k++) begin
				cur_q[k] <= '0;
				mag_q[k] <= '0;
				pos_q[k] <= '0;
			end
			neg_q <= '0;
			sum_q <= '0;
			len_q <= '0;
			k_q <= '0;
			clip_q <= 1'b0;
			mul_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q <= 1'b0;
			out_valid_q <= 1'b0;
			clipped_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_STEP_LIMIT:  step_limit_q <= cfg_data[SW-1:0];
					REG_SMOOTH_GAIN: smooth_gain_q <= cfg_data[GW-1:0];
					default:         step_limit_q <= step_limit_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						clip_q <= 1'b0;
						k_q <= '0;
						if (mode) begin
							for (int k = 0; k < 3; k++)
								cur_q[k] <= tgt[k];
							state_q <= ST_OUT;
						end else begin
							for (int k = 0; k < 3; k++) begin
								neg_q[k] <= dif[k][DW-1];
								mag_q[k] <= dif[k][DW-1] ? DW'(-dif[k]) : DW'(dif[k]);
							end
							gain_q <= (smooth_gain_q > GAIN_ONE) ? GAIN_ONE : smooth_gain_q;
							mul_go_q <= 1'b1;
							state_q <= ST_GAIN;
						end
					end
				end
				ST_GAIN: begin
					if (mul_done) begin
						mag_q[k_q] <= mul_prod[GAIN_SHIFT +: DW];
						mul_go_q <= 1'b1;
						if (k_q == 2'd2) begin
							k_q <= '0;
							sum_q <= '0;
							state_q <= ST_SQR;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						sum_q <= sum_q + mul_prod;
						if (k_q == 2'd2) begin
							sqrt_go_q <= 1'b1;
							state_q <= ST_ROOT;
						end else begin
							k_q <= k_q + 2'd1;
							mul_go_q <= 1'b1;
						end
					end
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						len_q <= sqrt_root;
						if (sqrt_root > DW'(step_limit_q)) begin
							clip_q <= 1'b1;
							k_q <= '0;
							mul_go_q <= 1'b1;
							state_q <= ST_SCALE;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_SCALE: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						mag_q[k_q] <= div_quot;
						if (k_q == 2'd2) begin
							state_q <= ST_UPD;
						end else begin
							k_q <= k_q + 2'd1;
							mul_go_q <= 1'b1;
							state_q <= ST_SCALE;
						end
					end
				end
				ST_UPD: begin
					for (int k = 0; k < 3; k++)
						cur_q[k] <= nxt[k][CW-1:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						for (int k = 0; k < 3; k++)
							pos_q[k] <= cur_q[k];
						clipped_q <= clip_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];
	assign clipped = clipped_q;

	assign scaling = (state_q == ST_SCALE || state_q == ST_DIV);
	assign root_short = state_q == ST_ROOT && sqrt_done && !(sqrt_root > DW'(step_limit_q));

	`ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted beat did not block input")
	`ASSERT_ALWAYS(a_scale_clip, scaling |-> clip_q, "scaling without clip")
	`ASSERT_NEXT(a_short_step, root_short, state_q == ST_UPD && !clip_q, "short step not updated")
endmodule
